FILE: rtl/iafd_pkg.sv
// Shared types and constants of the impact and fall detector.
// No dependencies; used by the interfaces, controller, datapath and top level.
package iafd_pkg;

   localparam int MagW    = 16;
   localparam int AngW    = 11;
   localparam int TimeW   = 32;
   localparam int CsrIdxW = 8;
   localparam int CsrDatW = 16;

   localparam int SqSteps     = 3;
   localparam int SqrtSteps   = 20;
   localparam int CordicSteps = 16;

   localparam logic [AngW-1:0] AngleMax  = 11'd1440;
   // |a|^2 below this means |a| < 0.01 g
   localparam logic [31:0]     SmallSum  = 32'd105;

   localparam logic [15:0] RstImpactThr = 16'd4096;
   localparam logic [15:0] RstJerkThr   = 16'd2048;
   localparam logic [10:0] RstAngleLim  = 11'd960;
   localparam logic [15:0] RstRestLim   = 16'd1536;
   localparam logic [15:0] RstDebounce  = 16'd500;
   localparam logic [15:0] RstWinOpen   = 16'd500;
   localparam logic [15:0] RstWinClose  = 16'd2000;
   localparam logic [15:0] RstTimeout   = 16'd2500;

   typedef enum logic [CsrIdxW-1:0] {
      REG_IMPACT_THR = 8'd0,
      REG_JERK_THR   = 8'd1,
      REG_ANGLE_LIM  = 8'd2,
      REG_REST_LIM   = 8'd3,
      REG_DEBOUNCE   = 8'd4,
      REG_WIN_OPEN   = 8'd5,
      REG_WIN_CLOSE  = 8'd6,
      REG_TIMEOUT    = 8'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_CORDIC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       sq_en;
      logic [1:0] sq_sel;
      logic       sqrt_en;
      logic       sqrt_last;
      logic       cordic_en;
      logic [3:0] idx;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } status_type;

   // arctan(2^-i) in 1/4096 degree
   function automatic logic [17:0] atan_lut(input logic [3:0] i);
      logic [17:0] v;
      case (i)
         4'd0:  v = 18'd184320;
         4'd1:  v = 18'd108810;
         4'd2:  v = 18'd57492;
         4'd3:  v = 18'd29184;
         4'd4:  v = 18'd14649;
         4'd5:  v = 18'd7331;
         4'd6:  v = 18'd3667;
         4'd7:  v = 18'd1833;
         4'd8:  v = 18'd917;
         4'd9:  v = 18'd458;
         4'd10: v = 18'd229;
         4'd11: v = 18'd115;
         4'd12: v = 18'd57;
         4'd13: v = 18'd29;
         4'd14: v = 18'd14;
         4'd15: v = 18'd7;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/iafd_if.sv
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on iafd_pkg for field widths.
interface iafd_req_if;
   logic                          valid;
   logic                          ready;
   logic [iafd_pkg::MagW-1:0]     accel_magnitude;
   logic signed [15:0]            accel_x;
   logic signed [15:0]            accel_y;
   logic signed [15:0]            accel_z;
   logic [iafd_pkg::TimeW-1:0]    time_ms;
   logic                          clear_impact;
   logic                          clear_fall;
   logic                          cancel_check;
   modport source (output valid, accel_magnitude, accel_x, accel_y, accel_z,
                   time_ms, clear_impact, clear_fall, cancel_check, input ready);
   modport sink   (input valid, accel_magnitude, accel_x, accel_y, accel_z,
                   time_ms, clear_impact, clear_fall, cancel_check, output ready);
endinterface

interface iafd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        impact_flag;
   logic                        fall_flag;
   logic                        fall_check_active;
   logic [iafd_pkg::MagW-1:0]   impact_peak;
   logic [iafd_pkg::AngW-1:0]   impact_angle;
   logic [iafd_pkg::AngW-1:0]   fall_angle;
   modport source (output valid, impact_flag, fall_flag, fall_check_active,
                   impact_peak, impact_angle, fall_angle, input ready);
   modport sink   (input valid, impact_flag, fall_flag, fall_check_active,
                   impact_peak, impact_angle, fall_angle, output ready);
endinterface

interface iafd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [iafd_pkg::CsrIdxW-1:0]   index;
   logic [iafd_pkg::CsrDatW-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/iafd_ctrl.sv
// Sequencer of the detector: squares, square root, CORDIC, then commit.
// Depends on iafd_pkg for the state, command and status types.
module iafd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  iafd_pkg::status_type status,
   output iafd_pkg::cmd_type    cmd
);

   iafd_pkg::state_type state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                accept;

   assign accept = req_valid && (state_ff == iafd_pkg::ST_IDLE);

   // Next state and step count
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 5'd1;
      case (state_ff)
         iafd_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept) state_in = iafd_pkg::ST_SQ;
         end
         iafd_pkg::ST_SQ: begin
            if (cnt_ff == 5'(iafd_pkg::SqSteps - 1)) begin
               state_in = iafd_pkg::ST_SQRT;
               cnt_in   = '0;
            end
         end
         iafd_pkg::ST_SQRT: begin
            if (cnt_ff == 5'(iafd_pkg::SqrtSteps - 1)) begin
               state_in = iafd_pkg::ST_CORDIC;
               cnt_in   = '0;
            end
         end
         iafd_pkg::ST_CORDIC: begin
            if (cnt_ff == 5'(iafd_pkg::CordicSteps - 1)) begin
               state_in = iafd_pkg::ST_DONE;
               cnt_in   = '0;
            end
         end
         iafd_pkg::ST_DONE: begin
            cnt_in = '0;
            if (!status.rsp_pending) state_in = iafd_pkg::ST_IDLE;
         end
         default: begin
            state_in = iafd_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.idx    = cnt_ff[3:0];
      cmd.sq_sel = cnt_ff[1:0];
      case (state_ff)
         iafd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = accept;
         end
         iafd_pkg::ST_SQ:     cmd.sq_en = 1'b1;
         iafd_pkg::ST_SQRT: begin
            cmd.sqrt_en   = 1'b1;
            cmd.sqrt_last = (cnt_ff == 5'(iafd_pkg::SqrtSteps - 1));
         end
         iafd_pkg::ST_CORDIC: cmd.cordic_en = 1'b1;
         iafd_pkg::ST_DONE:   cmd.commit = !status.rsp_pending;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iafd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/iafd_dp.sv
// Datapath of the detector: sample latch, squarer, root, CORDIC, detection
// state, register file and result register. Depends on iafd_pkg.
module iafd_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  iafd_pkg::cmd_type     cmd,
   output iafd_pkg::status_type  status,
   iafd_req_if.sink              req_ch,
   iafd_rsp_if.source            rsp_ch,
   iafd_csr_if.sink              csr_ch
);

   // Registers
   logic [15:0] impact_thr_ff, jerk_thr_ff, rest_lim_ff;
   logic [15:0] debounce_ff, win_open_ff, win_close_ff, timeout_ff;
   logic [10:0] angle_lim_ff;

   // Latched sample
   logic [15:0] mag_ff;
   logic [16:0] ax_ff, ay_ff, az_ff;
   logic [31:0] now_ff;
   logic        clr_imp_ff, clr_fall_ff, cancel_ff;

   // Arithmetic
   logic [31:0]        hsq_ff, hsq_in, sum_ff, sum_in;
   logic [16:0]        sq_op;
   logic [33:0]        sq_prod;
   logic [39:0]        rad_ff, rad_in;
   logic [23:0]        rem_ff, rem_in, rem_sh, rem_test;
   logic [19:0]        root_ff, root_in;
   logic signed [23:0] cx_ff, cx_in, cy_ff, cy_in, dx, dy, cy_neg;
   logic signed [21:0] acc_ff, acc_in, acc_rnd;
   logic signed [21:0] step_ang;

   // Detection state
   logic [15:0] prev_mag_ff;
   logic [31:0] impact_time_ff;
   logic        imp_seen_ff, fall_seen_ff, checking_ff;
   logic [15:0] peak_ff;
   logic [10:0] pre_ang_ff, post_ang_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_imp_ff, rsp_fall_ff, rsp_chk_ff;
   logic [15:0] rsp_peak_ff;
   logic [10:0] rsp_pre_ff, rsp_post_ff;

   // Commit logic
   logic [10:0] angle;
   logic [13:0] rnd_q;
   logic [15:0] jerk;
   logic        impact;
   logic        imp_n, fall_n, chk_n;
   logic [31:0] itime_n, elapsed;
   logic [15:0] peak_n;
   logic [10:0] pre_n, post_n, adiff;

   logic signed [16:0] sx, sy, sz;

   assign csr_ch.ready = 1'b1;
   assign status.rsp_pending = rsp_valid_ff && !rsp_ch.ready;

   // Sign-extended axes; their absolute values are taken when the sample is latched
   assign sx = {req_ch.accel_x[15], req_ch.accel_x};
   assign sy = {req_ch.accel_y[15], req_ch.accel_y};
   assign sz = {req_ch.accel_z[15], req_ch.accel_z};

   // Shared squarer
   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = ax_ff;
         2'd1:    sq_op = ay_ff;
         default: sq_op = az_ff;
      endcase
      sq_prod = sq_op * sq_op;
      hsq_in  = hsq_ff;
      sum_in  = sum_ff;
      if (cmd.sq_en) begin
         case (cmd.sq_sel)
            2'd0:    hsq_in = sq_prod[31:0];
            2'd1:    hsq_in = hsq_ff + sq_prod[31:0];
            default: sum_in = hsq_ff + sq_prod[31:0];
         endcase
      end
   end

   // Square root, two radicand bits per step; load on the last square step
   always_comb begin
      rem_sh   = {rem_ff[21:0], rad_ff[39:38]};
      rem_test = {2'b00, root_ff, 2'b01};
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (cmd.sq_en && cmd.sq_sel == 2'd2) begin
         rad_in  = {hsq_ff, 8'd0};
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sqrt_en) begin
         rad_in = {rad_ff[37:0], 2'b00};
         if (rem_sh >= rem_test) begin
            rem_in  = rem_sh - rem_test;
            root_in = {root_ff[18:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[18:0], 1'b0};
         end
      end
   end

   // CORDIC vectoring; seeded as the root finishes
   always_comb begin
      cy_neg   = -cy_ff;
      dx       = cy_ff[23] ? -(cy_neg >>> cmd.idx) : (cy_ff >>> cmd.idx);
      dy       = cx_ff >>> cmd.idx;
      step_ang = 22'(iafd_pkg::atan_lut(cmd.idx));
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      acc_in   = acc_ff;
      if (cmd.sqrt_en && cmd.sqrt_last) begin
         cx_in  = 24'({az_ff, 4'd0});
         cy_in  = 24'(root_in);
         acc_in = '0;
      end else if (cmd.cordic_en) begin
         if (cy_ff > 0) begin
            cx_in  = cx_ff + dx;
            cy_in  = cy_ff - dy;
            acc_in = acc_ff + step_ang;
         end else begin
            cx_in  = cx_ff - dx;
            cy_in  = cy_ff + dy;
            acc_in = acc_ff - step_ang;
         end
      end
   end

   // Tilt angle with special cases, round and clamp
   always_comb begin
      acc_rnd = acc_ff + 22'sd128;
      rnd_q   = 14'(acc_rnd[21:8]);
      if (sum_ff < iafd_pkg::SmallSum)  angle = iafd_pkg::AngleMax;
      else if (hsq_ff == '0)            angle = '0;
      else if (az_ff == '0)             angle = iafd_pkg::AngleMax;
      else if (acc_rnd[21])             angle = '0;
      else if (rnd_q > 14'(iafd_pkg::AngleMax)) angle = iafd_pkg::AngleMax;
      else                              angle = rnd_q[10:0];
   end

   // Impact and fall decisions
   always_comb begin
      jerk    = (mag_ff > prev_mag_ff) ? mag_ff - prev_mag_ff : prev_mag_ff - mag_ff;
      impact  = (mag_ff > impact_thr_ff) && (jerk > jerk_thr_ff) &&
                ((now_ff - impact_time_ff) > {16'd0, debounce_ff});
      imp_n   = impact || (imp_seen_ff && !clr_imp_ff);
      fall_n  = fall_seen_ff && !clr_fall_ff;
      chk_n   = impact || (checking_ff && !cancel_ff);
      itime_n = impact ? now_ff : impact_time_ff;
      peak_n  = impact ? mag_ff : peak_ff;
      pre_n   = impact ? angle : pre_ang_ff;
      post_n  = post_ang_ff;
      elapsed = now_ff - itime_n;
      adiff   = (angle > pre_n) ? angle - pre_n : pre_n - angle;
      if (chk_n) begin
         if (elapsed > {16'd0, win_open_ff} && elapsed < {16'd0, win_close_ff}) begin
            if (adiff > angle_lim_ff && mag_ff < rest_lim_ff) begin
               fall_n = 1'b1;
               post_n = angle;
            end
         end else if (elapsed > {16'd0, timeout_ff}) begin
            chk_n = 1'b0;
         end
      end
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ch.ready);

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         impact_thr_ff <= iafd_pkg::RstImpactThr;
         jerk_thr_ff   <= iafd_pkg::RstJerkThr;
         angle_lim_ff  <= iafd_pkg::RstAngleLim;
         rest_lim_ff   <= iafd_pkg::RstRestLim;
         debounce_ff   <= iafd_pkg::RstDebounce;
         win_open_ff   <= iafd_pkg::RstWinOpen;
         win_close_ff  <= iafd_pkg::RstWinClose;
         timeout_ff    <= iafd_pkg::RstTimeout;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            iafd_pkg::REG_IMPACT_THR: impact_thr_ff <= csr_ch.data;
            iafd_pkg::REG_JERK_THR:   jerk_thr_ff   <= csr_ch.data;
            iafd_pkg::REG_ANGLE_LIM:  angle_lim_ff  <= csr_ch.data[10:0];
            iafd_pkg::REG_REST_LIM:   rest_lim_ff   <= csr_ch.data;
            iafd_pkg::REG_DEBOUNCE:   debounce_ff   <= csr_ch.data;
            iafd_pkg::REG_WIN_OPEN:   win_open_ff   <= csr_ch.data;
            iafd_pkg::REG_WIN_CLOSE:  win_close_ff  <= csr_ch.data;
            iafd_pkg::REG_TIMEOUT:    timeout_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Latch the sample beat and hold the work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff      <= req_ch.accel_magnitude;
         ax_ff       <= sx[16] ? 17'(-sx) : 17'(sx);
         ay_ff       <= sy[16] ? 17'(-sy) : 17'(sy);
         az_ff       <= sz[16] ? 17'(-sz) : 17'(sz);
         now_ff      <= req_ch.time_ms;
         clr_imp_ff  <= req_ch.clear_impact;
         clr_fall_ff <= req_ch.clear_fall;
         cancel_ff   <= req_ch.cancel_check;
      end
      hsq_ff  <= hsq_in;
      sum_ff  <= sum_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      acc_ff  <= acc_in;
   end

   // Commit detection state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mag_ff    <= '0;
         impact_time_ff <= '0;
         imp_seen_ff    <= 1'b0;
         fall_seen_ff   <= 1'b0;
         checking_ff    <= 1'b0;
         peak_ff        <= '0;
         pre_ang_ff     <= '0;
         post_ang_ff    <= '0;
      end else if (cmd.commit) begin
         prev_mag_ff    <= mag_ff;
         impact_time_ff <= itime_n;
         imp_seen_ff    <= imp_n;
         fall_seen_ff   <= fall_n;
         checking_ff    <= chk_n;
         peak_ff        <= peak_n;
         pre_ang_ff     <= pre_n;
         post_ang_ff    <= post_n;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (cmd.commit) begin
         rsp_imp_ff  <= imp_n;
         rsp_fall_ff <= fall_n;
         rsp_chk_ff  <= chk_n;
         rsp_peak_ff <= peak_n;
         rsp_pre_ff  <= pre_n;
         rsp_post_ff <= post_n;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.impact_flag       = rsp_imp_ff;
   assign rsp_ch.fall_flag         = rsp_fall_ff;
   assign rsp_ch.fall_check_active = rsp_chk_ff;
   assign rsp_ch.impact_peak       = rsp_peak_ff;
   assign rsp_ch.impact_angle      = rsp_pre_ff;
   assign rsp_ch.fall_angle        = rsp_post_ff;

endmodule

FILE: rtl/impact_and_fall_detector.sv
// Impact and fall detector top level. A result follows its sample beat through
// 3 squarer steps, 20 root steps, 16 CORDIC steps and the commit into the
// result register. One sample is in work at a time: the shared squarer, the
// bit-serial root and the CORDIC unit serve it, and the next beat is taken in
// idle after the commit; a result held off by the receiver stalls the commit. Synchronous
// active-high reset restores register defaults and clears all detection state.
module impact_and_fall_detector (
   input  logic      clock,
   input  logic      reset,
   iafd_req_if.sink   req_ch,
   iafd_rsp_if.source rsp_ch,
   iafd_csr_if.sink   csr_ch
);

   iafd_pkg::cmd_type    cmd;
   iafd_pkg::status_type status;

   iafd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   iafd_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Angles stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.impact_angle <= 11'd1440) &&
                       (rsp_ch.fall_angle <= 11'd1440))
      else $error("angle out of range");

   // One sample at a time: no new beat right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("sample accepted while busy");

   // A result never appears in the cycle after a sample beat
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !$rose(rsp_ch.valid))
      else $error("result too early");

endmodule
